FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: src/oaid_pkg.sv
`default_nettype none

package oaid_pkg;

   // storage geometry
   localparam int DEPTH      = 256;
   localparam int WORD_BITS  = 32;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS   = (COUNT_BITS > 9) ? COUNT_BITS : 9;

   // read reduction grouping
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // request function codes
   localparam logic [2:0] FUNC_PUSH   = 3'd0;
   localparam logic [2:0] FUNC_POP    = 3'd1;
   localparam logic [2:0] FUNC_INSERT = 3'd2;
   localparam logic [2:0] FUNC_DELETE = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;
   localparam logic [2:0] FUNC_RESIZE = 3'd5;

   // response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_RANGE   = 2'd1;
   localparam logic [1:0] STAT_NOSPACE = 2'd2;

   // cell command codes
   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_INSERT = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] item_word;
      logic [7:0]  position;
      logic [8:0]  new_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_word;
      logic [8:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [IDX_BITS-1:0]  pos;
      logic [WORD_BITS-1:0] word;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: src/oaid_cell.sv
`default_nettype none

module oaid_cell
   import oaid_pkg::*;
(
   input  wire logic                 clock,
   input  wire cell_cmd_type         cmd,
   input  wire logic [IDX_BITS-1:0]  cell_index,
   input  wire logic [IDX_BITS-1:0]  rd_pos,
   input  wire logic [WORD_BITS-1:0] left_word,
   input  wire logic [WORD_BITS-1:0] right_word,
   output logic      [WORD_BITS-1:0] word_out,
   output logic      [WORD_BITS-1:0] sel_word
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;

   // next entry value from the broadcast command
   always_comb begin
      word_in = word_ff;
      unique case (cmd.kind)
         CMD_HOLD: begin
            word_in = word_ff;
         end
         CMD_WRITE: begin
            if (cell_index == cmd.pos) word_in = cmd.word;
         end
         CMD_INSERT: begin
            if (cell_index == cmd.pos)     word_in = cmd.word;
            else if (cell_index > cmd.pos) word_in = left_word;
         end
         CMD_DELETE: begin
            if (cell_index >= cmd.pos) word_in = right_word;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // neighbor hand-off and masked read contribution
   assign word_out = word_ff;
   assign sel_word = (cell_index == rd_pos) ? word_ff : '0;

endmodule

`default_nettype wire

FILE: src/oaid_read_tree.sv
`default_nettype none

module oaid_read_tree
   import oaid_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [WORD_BITS-1:0] sel_words [DEPTH],
   output logic      [WORD_BITS-1:0] read_word
);

   logic [WORD_BITS-1:0] group_ff [NUM_GROUPS];
   logic [WORD_BITS-1:0] group_in [NUM_GROUPS];

   // first level: or of each group of cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < DEPTH) begin
               group_in[g] = group_in[g] | sel_words[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // second level: or across groups
   always_comb begin
      read_word = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         read_word = read_word | group_ff[g];
      end
   end

endmodule

`default_nettype wire

FILE: src/ordered_array_insert_delete.sv
// response: registered straight from the request transfer for every request except an in-range
// read, which passes the read position and first-level group registers of the two-level or over
// the cell outputs before the response register. Throughput: one request per cycle while
// responses drain; an in-range read holds the request side until the sequencer returns to idle
// insert and delete update all cells from the given position upward in the same cycle
// reset: synchronous, clears the entry count and handshake state; entry words are not cleared
`default_nettype none

`include "assert_macros.svh"

module ordered_array_insert_delete
   import oaid_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_GATHER = 2'd1;
   localparam logic [1:0] S_REDUCE = 2'd2;

   logic [1:0]            state_ff;
   logic [1:0]            state_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [IDX_BITS-1:0]   rd_pos_ff;
   logic [IDX_BITS-1:0]   rd_pos_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic                  req_fire;
   logic                  slot_free;
   logic                  start_read;
   logic [1:0]            status;
   cell_cmd_type          cmd;
   logic [CMP_BITS-1:0]   count_cmp;
   logic [CMP_BITS-1:0]   pos_cmp;
   logic [CMP_BITS-1:0]   req_cmp;
   logic                  is_full;
   logic [WORD_BITS-1:0]  in_word;
   logic [WORD_BITS-1:0]  cell_words [DEPTH];
   logic [WORD_BITS-1:0]  sel_words  [DEPTH];
   logic [WORD_BITS-1:0]  tree_word;

   // handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // widened operands for range checks
   assign count_cmp = CMP_BITS'(count_ff);
   assign pos_cmp   = CMP_BITS'(req_payload.position);
   assign req_cmp   = CMP_BITS'(req_payload.new_count);
   assign is_full   = (count_ff == COUNT_BITS'(DEPTH));
   assign in_word   = WORD_BITS'(req_payload.item_word);

   // request decode: status, count update and cell command
   always_comb begin
      status     = STAT_OK;
      count_in   = count_ff;
      start_read = 1'b0;
      cmd.kind   = CMD_HOLD;
      cmd.pos    = IDX_BITS'(req_payload.position);
      cmd.word   = in_word;
      if (req_fire) begin
         unique case (req_payload.func)
            FUNC_PUSH: begin
               if (is_full) begin
                  status = STAT_NOSPACE;
               end else begin
                  cmd.kind = CMD_WRITE;
                  cmd.pos  = IDX_BITS'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_POP: begin
               if (count_ff == '0) status = STAT_RANGE;
               else                count_in = count_ff - 1'b1;
            end
            FUNC_INSERT: begin
               if (pos_cmp >= count_cmp) begin
                  status = STAT_RANGE;
               end else if (is_full) begin
                  status = STAT_NOSPACE;
               end else begin
                  cmd.kind = CMD_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_DELETE: begin
               if (pos_cmp >= count_cmp) begin
                  status = STAT_RANGE;
               end else begin
                  cmd.kind = CMD_DELETE;
                  count_in = count_ff - 1'b1;
               end
            end
            FUNC_READ: begin
               if (pos_cmp >= count_cmp) status = STAT_RANGE;
               else                      start_read = 1'b1;
            end
            FUNC_RESIZE: begin
               if (req_cmp > CMP_BITS'(DEPTH)) status = STAT_NOSPACE;
               else if (req_cmp < count_cmp)   count_in = COUNT_BITS'(req_cmp);
            end
            default: begin
               status = STAT_RANGE;
            end
         endcase
      end
   end

   // sequencer and response register
   always_comb begin
      state_in     = state_ff;
      rd_pos_in    = rd_pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && start_read) begin
               rd_pos_in = IDX_BITS'(req_payload.position);
               state_in  = S_GATHER;
            end else if (req_fire) begin
               rsp_in.status      = status;
               rsp_in.read_word   = '0;
               rsp_in.entry_count = 9'(count_in);
               rsp_valid_in       = 1'b1;
            end
         end
         S_GATHER: begin
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            rsp_in.status      = STAT_OK;
            rsp_in.read_word   = 32'(tree_word);
            rsp_in.entry_count = 9'(count_ff);
            rsp_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= rd_pos_in;
      rsp_ff    <= rsp_in;
   end

   // chain of entry cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_mid_left
         assign left_word = cell_words[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_mid_right
         assign right_word = cell_words[i+1];
      end

      oaid_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_BITS'(i)),
         .rd_pos     (rd_pos_ff),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_words[i]),
         .sel_word   (sel_words[i])
      );
   end

   // read-out reduction
   oaid_read_tree u_read_tree (
      .clock     (clock),
      .sel_words (sel_words),
      .read_word (tree_word)
   );

   // checks
   `ASSERT_NEVER(a_count_bound, count_ff > COUNT_BITS'(DEPTH), "entry count above depth")
   `ASSERT_PROP(a_count_needs_transfer, !req_fire |=> $stable(count_ff), "count moved idle")
   `ASSERT_PROP(a_gather_to_reduce, state_ff == S_GATHER |=> state_ff == S_REDUCE, "read sequence broken")
   `ASSERT_NEVER(a_no_rsp_during_read, state_ff != S_IDLE && rsp_valid_ff, "response pending during read")

endmodule

`default_nettype wire

FILE: dv/ordered_array_insert_delete_tb.sv
module ordered_array_insert_delete_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import oaid_pkg::*;

   localparam int CLOCK_HALF       = 6;
   localparam int RESET_CYCLES     = 2;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES    = 10;
   localparam int TIMEOUT_CYCLES   = 200000;
   localparam int PRINT_CAP        = 30;

   // func codes the block does not define
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   typedef enum logic [1:0] {MIX_BALANCED, MIX_GROW, MIX_SHRINK} op_mix_type;

   // contents of the array as the block should hold them
   typedef struct packed {
      logic [DEPTH-1:0][WORD_BITS-1:0] words;
      logic [COUNT_BITS-1:0]           count;
   } array_state_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   req_type req_payload = '0;
   logic    rsp_ready   = 1'b0;
   logic    req_ready;
   logic    rsp_valid;
   rsp_type rsp_payload;

   req_type         request_backlog[$];
   rsp_type         due_responses[$];
   array_state_type planned_array = '0;
   array_state_type tracked_array = '0;

   int error_count   = 0;
   int checked_count = 0;
   int queued_count  = 0;
   int cycle_count   = 0;
   int peak_fill     = 0;
   int func_tally[8];
   int status_tally[4];
   int hold_asked    = 0;
   int hold_served   = 0;
   int send_gap      = 0;
   int send_quiet    = 0;
   int rsp_stall     = 0;
   int rsp_quiet     = 0;

   logic    offer_valid;
   req_type offer;
   rsp_type due_rsp;
   rsp_type predicted_rsp;

   ordered_array_insert_delete dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // apply one request to an array image, return the response it earns
   function automatic rsp_type apply_to_array(input req_type r, inout array_state_type s);
      rsp_type a;
      int      i;
      a = '0;
      a.status = STAT_OK;
      case (r.func)
         FUNC_PUSH: begin
            if (s.count >= DEPTH) begin
               a.status = STAT_NOSPACE;
            end else begin
               s.words[s.count[IDX_BITS-1:0]] = r.item_word;
               s.count = s.count + 1'b1;
            end
         end
         FUNC_POP: begin
            if (s.count == 0) a.status = STAT_RANGE;
            else s.count = s.count - 1'b1;
         end
         FUNC_INSERT: begin
            // an index equal to the count is out of range too
            if (r.position >= s.count) begin
               a.status = STAT_RANGE;
            end else if (s.count >= DEPTH) begin
               a.status = STAT_NOSPACE;
            end else begin
               for (i = s.count; i > r.position; i--) s.words[i] = s.words[i-1];
               s.words[r.position] = r.item_word;
               s.count = s.count + 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (r.position >= s.count) begin
               a.status = STAT_RANGE;
            end else begin
               for (i = r.position; i + 1 < s.count; i++) s.words[i] = s.words[i+1];
               s.count = s.count - 1'b1;
            end
         end
         FUNC_READ: begin
            if (r.position >= s.count) a.status = STAT_RANGE;
            else a.read_word = s.words[r.position];
         end
         FUNC_RESIZE: begin
            // resize only ever truncates
            if (r.new_count > DEPTH) a.status = STAT_NOSPACE;
            else if (r.new_count < s.count) s.count = r.new_count;
         end
         default: a.status = STAT_RANGE;
      endcase
      a.entry_count = s.count;
      return a;
   endfunction

   // idle length: mostly short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 8);
      return $urandom_range(9, 25);
   endfunction

   function automatic req_type build_request(input logic [2:0] f, input logic [31:0] w,
                                             input logic [7:0] p, input logic [8:0] n);
      req_type r;
      r.func      = f;
      r.item_word = w;
      r.position  = p;
      r.new_count = n;
      return r;
   endfunction

   // random request, operation mix steered toward growing or shrinking the array
   function automatic req_type random_request(input op_mix_type mix,
                                              input logic [COUNT_BITS-1:0] cnt);
      req_type r;
      int      weights[7];
      int      roll;
      int      slot;
      r.item_word = $urandom();
      roll = $urandom_range(0, 15);
      if (roll == 0) r.item_word = '0;
      else if (roll == 1) r.item_word = '1;

      // mostly valid indexes, some at the count, some anywhere
      roll = $urandom_range(0, 99);
      if (cnt != 0 && roll < 80) r.position = 8'($urandom_range(0, cnt - 1));
      else if (roll < 90) r.position = cnt[7:0];
      else r.position = 8'($urandom_range(0, 255));

      roll = $urandom_range(0, 99);
      if (roll < 60) r.new_count = 9'($urandom_range(0, cnt));
      else if (roll < 80) r.new_count = 9'($urandom_range(cnt, DEPTH));
      else r.new_count = 9'($urandom_range(0, 511));

      // slots: push pop insert delete read resize unused
      case (mix)
         MIX_GROW:   weights = '{60, 2, 27, 5, 5, 0, 1};
         MIX_SHRINK: weights = '{10, 20, 10, 25, 20, 12, 3};
         default:    weights = '{25, 10, 20, 15, 20, 7, 3};
      endcase
      roll = $urandom_range(0, 99);
      slot = 0;
      while (slot < 6 && roll >= weights[slot]) begin
         roll -= weights[slot];
         slot++;
      end
      case (slot)
         0:       r.func = FUNC_PUSH;
         1:       r.func = FUNC_POP;
         2:       r.func = FUNC_INSERT;
         3:       r.func = FUNC_DELETE;
         4:       r.func = FUNC_READ;
         5:       r.func = FUNC_RESIZE;
         default: r.func = $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
      endcase
      return r;
   endfunction

   // queue a request and track where the array will stand after it
   task automatic queue_request(input req_type r);
      request_backlog.insert(request_backlog.size(), r);
      queued_count++;
      void'(apply_to_array(r, planned_array));
   endtask

   // wait until every queued request has had its response checked
   task automatic wait_drained();
      while (checked_count < queued_count)
         @(posedge clock);
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("%0t: response %0d, %s: got %h, expected %h",
                  $realtime, checked_count, what, got, want);
      error_count++;
   endtask

   // request side: offer backlog items, predict each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
         send_quiet = 0;
      end else begin
         offer_valid = req_valid;
         offer = req_payload;
         if (req_valid && req_ready) begin
            predicted_rsp = apply_to_array(req_payload, tracked_array);
            due_responses.insert(due_responses.size(), predicted_rsp);
            func_tally[req_payload.func]++;
            status_tally[predicted_rsp.status]++;
            if (tracked_array.count > peak_fill) peak_fill = tracked_array.count;
            offer_valid = 1'b0;
            if (send_quiet > 0) begin
               send_quiet--;
               send_gap = 0;
            end else if ($urandom_range(0, 59) == 0) begin
               send_quiet = $urandom_range(30, 80);
               send_gap = 0;
            end else begin
               send_gap = pick_gap();
            end
         end
         if (!offer_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (request_backlog.size() != 0) begin
               offer = request_backlog.pop_front();
               offer_valid = 1'b1;
            end
         end
         req_valid <= offer_valid;
         req_payload <= offer;
      end
   end

   // response side ready: random stalls, quiet stretches, one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
         rsp_quiet = 0;
      end else begin
         if (rsp_stall > 0) begin
            rsp_stall--;
         end else if (hold_served < hold_asked) begin
            hold_served++;
            rsp_stall = LONG_HOLD_CYCLES;
         end else if (rsp_quiet > 0) begin
            if (rsp_valid && rsp_ready) rsp_quiet--;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_quiet = $urandom_range(30, 80);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall = pick_gap();
         end
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (due_responses.size() == 0) begin
            flag_mismatch("response with nothing outstanding", rsp_payload.read_word, '0);
         end else begin
            due_rsp = due_responses.pop_front();
            if (rsp_payload.status !== due_rsp.status)
               flag_mismatch("status", 32'(rsp_payload.status), 32'(due_rsp.status));
            if (rsp_payload.read_word !== due_rsp.read_word)
               flag_mismatch("read_word", rsp_payload.read_word, due_rsp.read_word);
            if (rsp_payload.entry_count !== due_rsp.entry_count)
               flag_mismatch("entry_count", 32'(rsp_payload.entry_count),
                             32'(due_rsp.entry_count));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, due_responses.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int guard;
      int k;
      foreach (func_tally[k]) func_tally[k] = 0;
      foreach (status_tally[k]) status_tally[k] = 0;

      // directed: empty array corners
      queue_request(build_request(FUNC_POP, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_DELETE, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_READ, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_INSERT, 32'hDEADBEEF, 8'd0, 9'd0));
      // fill a few, insert in front, insert at the count
      queue_request(build_request(FUNC_PUSH, 32'h00000000, 8'd0, 9'd0));
      queue_request(build_request(FUNC_PUSH, 32'hFFFFFFFF, 8'd255, 9'd511));
      queue_request(build_request(FUNC_PUSH, 32'hA5A5A5A5, 8'd0, 9'd0));
      queue_request(build_request(FUNC_INSERT, 32'h12345678, 8'd0, 9'd0));
      queue_request(build_request(FUNC_INSERT, 32'h5A5A5A5A, 8'd4, 9'd0));
      queue_request(build_request(FUNC_READ, 32'h0, 8'd3, 9'd0));
      queue_request(build_request(FUNC_READ, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_READ, 32'h0, 8'd255, 9'd0));
      queue_request(build_request(FUNC_DELETE, 32'h0, 8'd1, 9'd0));
      queue_request(build_request(FUNC_DELETE, 32'h0, 8'd255, 9'd0));
      // resize: beyond depth, at depth, just past, larger, smaller
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd511));
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd256));
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd257));
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd5));
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd1));
      queue_request(build_request(FUNC_READ, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_UNUSED_LO, 32'hFFFFFFFF, 8'd0, 9'd0));
      queue_request(build_request(FUNC_UNUSED_HI, 32'h0, 8'd255, 9'd511));
      queue_request(build_request(FUNC_POP, 32'h0, 8'd0, 9'd0));
      queue_request(build_request(FUNC_RESIZE, 32'h0, 8'd0, 9'd0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // queue nothing more until every directed response is checked
      wait_drained();

      // balanced random traffic
      for (k = 0; k < 60; k++) queue_request(random_request(MIX_BALANCED, planned_array.count));
      wait_drained();

      // grow to full under a long response hold, then work at full
      hold_asked++;
      guard = 0;
      while (planned_array.count < DEPTH && guard < 1000) begin
         queue_request(random_request(MIX_GROW, planned_array.count));
         guard++;
      end
      for (k = 0; k < 30; k++) queue_request(random_request(MIX_GROW, planned_array.count));

      // shrink and mix
      for (k = 0; k < 80; k++) queue_request(random_request(MIX_SHRINK, planned_array.count));

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered push %0d, pop %0d, insert %0d, delete %0d, read %0d, resize %0d, unused %0d",
               func_tally[FUNC_PUSH], func_tally[FUNC_POP], func_tally[FUNC_INSERT],
               func_tally[FUNC_DELETE], func_tally[FUNC_READ], func_tally[FUNC_RESIZE],
               func_tally[FUNC_UNUSED_LO] + func_tally[FUNC_UNUSED_HI]);
      $display("%0d responses checked (ok %0d, range %0d, no space %0d), peak fill %0d of %0d",
               checked_count, status_tally[STAT_OK], status_tally[STAT_RANGE],
               status_tally[STAT_NOSPACE], peak_fill, DEPTH);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/oaid_pkg.sv
src/oaid_cell.sv
src/oaid_read_tree.sv
src/ordered_array_insert_delete.sv
dv/ordered_array_insert_delete_tb.sv
